// ----- src/bpa_pkg.sv -----
// Package with the shared types and constants of the bitmap page allocator.
package bpa_pkg;

    localparam int MaxBlocks = 65536;
    localparam int WordBits  = 32;
    localparam int MapWords  = MaxBlocks / WordBits;
    localparam int AddrW     = $clog2(MapWords);
    localparam int BitW      = $clog2(WordBits);
    localparam int CountW    = 17;
    localparam int IndexW    = 16;

    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_FREE    = 3'd1,
        OP_RESERVE = 3'd2,
        OP_QUERY   = 3'd3,
        OP_FIND    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOTFND  = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_MARK_RD,
        S_MARK,
        S_QUERY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        op;
        logic [IndexW-1:0] start_block;
        logic [CountW-1:0] count;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [IndexW-1:0] first_block;
        logic              block_free;
        logic [CountW-1:0] used_blocks;
    } t_rsp;

endpackage

// ----- src/bpa_if.sv -----
// Valid/ready channel interfaces for requests and responses.
interface bpa_req_if;
    logic          valid;
    logic          ready;
    bpa_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bpa_rsp_if;
    logic          valid;
    logic          ready;
    bpa_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/bitmap_page_allocator.sv -----
// Top level of the bitmap page allocator with usage map memory and sequencer.
//
// Requests arrive on i_req as words of op, start_block and count; one response
// word per request leaves on o_rsp with status, first_block, block_free and
// the used block count. i_cfg_we with i_cfg_data sets total_blocks and must
// only be used while no request is in flight.
// The usage map is a 2048 x 32 bit synchronous memory. The sequencer reads it
// once per cycle and examines one block per cycle while scanning. An unknown
// op goes straight to the response and a query reads its block once; a free
// or reserve reads and then writes each block of its range in turn, and a
// search scans blocks until it finds a match or passes total_blocks; an
// allocation then marks the found run block by block. One request is in work
// at a time; the next is accepted in the cycle after the response is taken.
// After reset all 2048 map words are cleared in turn, during which no
// request is accepted. The response is held in an output register until taken;
// while it waits the next request is not accepted.
module bitmap_page_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bpa_pkg::CountW-1:0] i_cfg_data,
    bpa_req_if.sink                    i_req,
    bpa_rsp_if.source                  o_rsp
);

    bpa_pkg::t_state r_state, n_state;
    logic [bpa_pkg::CountW-1:0] r_total;
    logic [bpa_pkg::CountW-1:0] r_used, n_used;
    bpa_pkg::t_req r_req;
    logic [bpa_pkg::CountW-1:0] r_pos, n_pos;
    logic [bpa_pkg::CountW-1:0] r_run, n_run;
    logic [bpa_pkg::CountW-1:0] r_base, n_base;
    logic [bpa_pkg::CountW-1:0] r_end, n_end;
    logic r_mark_val, n_mark_val;
    bpa_pkg::t_rsp r_rsp, n_rsp;
    logic [bpa_pkg::AddrW-1:0] r_clr, n_clr;

    logic [bpa_pkg::WordBits-1:0] r_map [bpa_pkg::MapWords];
    logic [bpa_pkg::WordBits-1:0] r_rd;
    logic [bpa_pkg::AddrW-1:0] rd_addr;
    logic we;
    logic [bpa_pkg::AddrW-1:0] wr_addr;
    logic [bpa_pkg::WordBits-1:0] wr_data;

    logic [bpa_pkg::CountW-1:0] eff_total;
    logic cur_bit;
    logic [bpa_pkg::CountW:0] run_end;

    always_comb begin
        if (r_total == '0) begin
            eff_total = bpa_pkg::CountW'(1);
        end else if (r_total > bpa_pkg::CountW'(bpa_pkg::MaxBlocks)) begin
            eff_total = bpa_pkg::CountW'(bpa_pkg::MaxBlocks);
        end else begin
            eff_total = r_total;
        end
    end

    assign cur_bit = r_rd[r_pos[bpa_pkg::BitW-1:0]];
    assign run_end = {2'b0, i_req.data.start_block} + {1'b0, i_req.data.count};

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_map[wr_addr] <= wr_data;
        end
        r_rd <= r_map[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpa_pkg::S_CLEAR;
            r_total <= bpa_pkg::CountW'(bpa_pkg::MaxBlocks);
            r_used  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        r_pos      <= n_pos;
        r_run      <= n_run;
        r_base     <= n_base;
        r_end      <= n_end;
        r_mark_val <= n_mark_val;
        r_rsp      <= n_rsp;
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            bpa_pkg::S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == bpa_pkg::AddrW'(bpa_pkg::MapWords - 1)) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.data.op)
                        bpa_pkg::OP_ALLOC, bpa_pkg::OP_FIND: begin
                            n_state = bpa_pkg::S_SCAN_RD;
                        end
                        bpa_pkg::OP_FREE, bpa_pkg::OP_RESERVE: begin
                            n_state = bpa_pkg::S_MARK_RD;
                        end
                        bpa_pkg::OP_QUERY: n_state = bpa_pkg::S_QUERY;
                        default: n_state = bpa_pkg::S_DONE;
                    endcase
                end
            end
            bpa_pkg::S_SCAN_RD: begin
                if (r_req.op == bpa_pkg::OP_ALLOC && r_req.count != '0 &&
                    r_used < eff_total && r_req.count <= eff_total) begin
                    n_state = bpa_pkg::S_SCAN;
                end else if (r_req.op == bpa_pkg::OP_FIND &&
                    {1'b0, r_req.start_block} < eff_total) begin
                    n_state = bpa_pkg::S_SCAN;
                end else begin
                    n_state = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_SCAN: begin
                if (r_pos >= eff_total) begin
                    n_state = bpa_pkg::S_DONE;
                end else if (!cur_bit && r_req.op == bpa_pkg::OP_FIND) begin
                    n_state = bpa_pkg::S_DONE;
                end else if (!cur_bit && r_run + 1'b1 == r_req.count) begin
                    n_state = bpa_pkg::S_MARK_RD;
                end
            end
            bpa_pkg::S_MARK_RD: begin
                if (r_pos >= r_end) begin
                    n_state = bpa_pkg::S_DONE;
                end else begin
                    n_state = bpa_pkg::S_MARK;
                end
            end
            bpa_pkg::S_MARK: n_state = bpa_pkg::S_MARK_RD;
            bpa_pkg::S_QUERY: n_state = bpa_pkg::S_DONE;
            bpa_pkg::S_DONE: begin
                if (o_rsp.ready) begin
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: n_state = bpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_used     = r_used;
        n_pos      = r_pos;
        n_run      = r_run;
        n_base     = r_base;
        n_end      = r_end;
        n_mark_val = r_mark_val;
        n_rsp      = r_rsp;
        rd_addr    = r_pos[bpa_pkg::BitW +: bpa_pkg::AddrW];
        we         = 1'b0;
        wr_addr    = r_pos[bpa_pkg::BitW +: bpa_pkg::AddrW];
        wr_data    = r_rd;
        i_req.ready = (r_state == bpa_pkg::S_IDLE);
        case (r_state)
            bpa_pkg::S_CLEAR: begin
                we      = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            bpa_pkg::S_IDLE: begin
                n_rsp = '{status: bpa_pkg::ST_OK, first_block: '0,
                          block_free: 1'b0, used_blocks: r_used};
                n_run = '0;
                n_mark_val = (i_req.data.op == bpa_pkg::OP_RESERVE) ||
                             (i_req.data.op == bpa_pkg::OP_ALLOC);
                if (i_req.data.op == bpa_pkg::OP_ALLOC ||
                    i_req.data.start_block == '0) begin
                    n_pos = bpa_pkg::CountW'(1);
                end else begin
                    n_pos = {1'b0, i_req.data.start_block};
                end
                if (i_req.data.op == bpa_pkg::OP_QUERY ||
                    i_req.data.op == bpa_pkg::OP_RESERVE) begin
                    n_pos = {1'b0, i_req.data.start_block};
                end
                rd_addr = n_pos[bpa_pkg::BitW +: bpa_pkg::AddrW];
                n_end = n_pos + i_req.data.count;
                if (i_req.valid) begin
                    case (i_req.data.op)
                        bpa_pkg::OP_ALLOC, bpa_pkg::OP_FIND,
                        bpa_pkg::OP_QUERY: ;
                        bpa_pkg::OP_FREE, bpa_pkg::OP_RESERVE: begin
                            if (i_req.data.count == '0 ||
                                run_end > {1'b0, eff_total} ||
                                (i_req.data.op == bpa_pkg::OP_FREE &&
                                 i_req.data.start_block == '0)) begin
                                n_rsp.status = bpa_pkg::ST_INVALID;
                                n_end = n_pos;
                            end
                        end
                        default: n_rsp.status = bpa_pkg::ST_INVALID;
                    endcase
                end
            end
            bpa_pkg::S_SCAN_RD: begin
                if (r_req.op == bpa_pkg::OP_ALLOC) begin
                    if (r_req.count == '0) begin
                        n_rsp.status = bpa_pkg::ST_INVALID;
                    end else if (r_used >= eff_total || r_req.count > eff_total) begin
                        n_rsp.status = bpa_pkg::ST_NOTFND;
                    end
                end else if ({1'b0, r_req.start_block} >= eff_total) begin
                    n_rsp.status = bpa_pkg::ST_INVALID;
                end
            end
            bpa_pkg::S_SCAN: begin
                if (r_pos >= eff_total) begin
                    n_rsp.status = bpa_pkg::ST_NOTFND;
                end else if (!cur_bit && r_req.op == bpa_pkg::OP_FIND) begin
                    n_rsp.first_block = r_pos[bpa_pkg::IndexW-1:0];
                end else begin
                    n_run = cur_bit ? '0 : r_run + 1'b1;
                    if (!cur_bit && r_run + 1'b1 == r_req.count) begin
                        n_base = r_pos + 1'b1 - r_req.count;
                        n_rsp.first_block = n_base[bpa_pkg::IndexW-1:0];
                        n_end = r_pos + 1'b1;
                        n_pos = n_base;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                rd_addr = n_pos[bpa_pkg::BitW +: bpa_pkg::AddrW];
            end
            bpa_pkg::S_MARK: begin
                we = 1'b1;
                wr_data[r_pos[bpa_pkg::BitW-1:0]] = r_mark_val;
                if (cur_bit != r_mark_val) begin
                    n_used = r_mark_val ? r_used + 1'b1 : r_used - 1'b1;
                end
                n_pos = r_pos + 1'b1;
                rd_addr = n_pos[bpa_pkg::BitW +: bpa_pkg::AddrW];
            end
            bpa_pkg::S_QUERY: begin
                if ({1'b0, r_req.start_block} >= eff_total) begin
                    n_rsp.status = bpa_pkg::ST_INVALID;
                end else begin
                    n_rsp.block_free = !cur_bit;
                end
            end
            default: ;
        endcase
        n_rsp.used_blocks = n_used;
    end

    assign o_rsp.valid = (r_state == bpa_pkg::S_DONE);
    assign o_rsp.data  = r_rsp;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= bpa_pkg::CountW'(bpa_pkg::MaxBlocks))
        else $error("used count above map size");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request accepted while response pending");
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bpa_pkg::S_MARK) |=> (r_used == $past(r_used)))
        else $error("used count changed outside marking");
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status != bpa_pkg::ST_OK)
            |-> (o_rsp.data.first_block == '0))
        else $error("failure with nonzero index");
`endif

endmodule

// ----- tb/sv/bitmap_page_allocator_tb.sv -----
// Self-checking testbench of the bitmap page allocator: directed table, then random phases.
module bitmap_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]                 op;
        logic [bpa_pkg::IndexW-1:0] start_block;
        logic [bpa_pkg::CountW-1:0] count;
        bit                         typed;
        bpa_pkg::t_rsp              rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [bpa_pkg::CountW-1:0] i_cfg_data = '0;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    bitmap_page_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    bit            block_used [bpa_pkg::MaxBlocks];
    int unsigned   used_total;
    int unsigned   total_setting = bpa_pkg::MaxBlocks;
    bpa_pkg::t_rsp pending_rsp [$];
    int            mismatches;
    int            words_sent;
    int            words_checked;
    bit            quiet;
    bit            hold_req;

    always #5 i_clk = ~i_clk;

    initial begin
        #200ms;
        $display("bitmap_page_allocator_tb NOT OK");
        $finish;
    end

    function automatic int unsigned managed_blocks();
        if (total_setting == 0) return 1;
        if (total_setting > bpa_pkg::MaxBlocks) return bpa_pkg::MaxBlocks;
        return total_setting;
    endfunction

    function automatic void mark_block(int unsigned b, bit used);
        if (block_used[b] != used) begin
            block_used[b] = used;
            if (used) used_total++;
            else used_total--;
        end
    endfunction

    function automatic bpa_pkg::t_rsp allocator_step(bpa_pkg::t_req r);
        int unsigned   tot;
        int unsigned   st;
        int unsigned   cnt;
        int unsigned   run;
        int unsigned   i;
        bpa_pkg::t_rsp o;
        tot = managed_blocks();
        st  = r.start_block;
        cnt = r.count;
        o   = '0;
        o.status = bpa_pkg::ST_OK;
        case (r.op)
            bpa_pkg::OP_ALLOC: begin
                if (cnt == 0) o.status = bpa_pkg::ST_INVALID;
                else if (used_total >= tot || cnt > tot) o.status = bpa_pkg::ST_NOTFND;
                else begin
                    run = 0;
                    o.status = bpa_pkg::ST_NOTFND;
                    for (i = 1; i < tot; i++) begin
                        run = block_used[i] ? 0 : run + 1;
                        if (run == cnt) begin
                            o.status = bpa_pkg::ST_OK;
                            break;
                        end
                    end
                    if (o.status == bpa_pkg::ST_OK) begin
                        o.first_block = bpa_pkg::IndexW'(i + 1 - cnt);
                        for (int unsigned k = i + 1 - cnt; k <= i; k++) mark_block(k, 1'b1);
                    end
                end
            end
            bpa_pkg::OP_FREE, bpa_pkg::OP_RESERVE: begin
                if (cnt == 0 || st + cnt > tot || (r.op == bpa_pkg::OP_FREE && st == 0)) begin
                    o.status = bpa_pkg::ST_INVALID;
                end else begin
                    for (i = st; i < st + cnt; i++)
                        mark_block(i, r.op == bpa_pkg::OP_RESERVE);
                end
            end
            bpa_pkg::OP_QUERY: begin
                if (st >= tot) o.status = bpa_pkg::ST_INVALID;
                else o.block_free = !block_used[st];
            end
            bpa_pkg::OP_FIND: begin
                if (st >= tot) o.status = bpa_pkg::ST_INVALID;
                else begin
                    o.status = bpa_pkg::ST_NOTFND;
                    for (i = (st == 0) ? 1 : st; i < tot; i++) begin
                        if (!block_used[i]) begin
                            o.status = bpa_pkg::ST_OK;
                            o.first_block = bpa_pkg::IndexW'(i);
                            break;
                        end
                    end
                end
            end
            default: o.status = bpa_pkg::ST_INVALID;
        endcase
        o.used_blocks = bpa_pkg::CountW'(used_total);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("MISMATCH word %0d %s: got %0d expected %0d", words_checked, what, got, want);
    endtask

    always @(posedge i_clk) begin
        bpa_pkg::t_rsp want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.data.status !== want.status)
                    report_mismatch("status", rsp_ch.data.status, want.status);
                if (rsp_ch.data.first_block !== want.first_block)
                    report_mismatch("first_block", rsp_ch.data.first_block, want.first_block);
                if (rsp_ch.data.block_free !== want.block_free)
                    report_mismatch("block_free", rsp_ch.data.block_free, want.block_free);
                if (rsp_ch.data.used_blocks !== want.used_blocks)
                    report_mismatch("used_blocks", rsp_ch.data.used_blocks, want.used_blocks);
            end
            words_checked++;
        end
    end

    initial begin
        int idle_left;
        idle_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                rsp_ch.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (!quiet && idle_left == 0 && $urandom_range(0, 5) == 0)
                idle_left = $urandom_range(1, 11);
            if (quiet) idle_left = 0;
            rsp_ch.ready = (idle_left == 0);
            if (idle_left > 0) idle_left--;
        end
    end

    task automatic send_word(bpa_pkg::t_req r, bit typed, bpa_pkg::t_rsp typed_rsp);
        bpa_pkg::t_rsp predicted;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = allocator_step(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_ch.valid = 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_total(int unsigned value);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = bpa_pkg::CountW'(value);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        total_setting = value;
    endtask

    function automatic bpa_pkg::t_req random_word();
        int unsigned  tot;
        int unsigned  pick;
        int unsigned  cmax;
        bpa_pkg::t_req r;
        tot  = managed_blocks();
        pick = $urandom_range(0, 99);
        cmax = (tot > 1000) ? 8 : tot + 1;
        if (pick < 30)      r.op = bpa_pkg::OP_ALLOC;
        else if (pick < 50) r.op = bpa_pkg::OP_FREE;
        else if (pick < 65) r.op = bpa_pkg::OP_RESERVE;
        else if (pick < 80) r.op = bpa_pkg::OP_QUERY;
        else if (pick < 95) r.op = bpa_pkg::OP_FIND;
        else                r.op = 3'($urandom_range(5, 7));
        r.count = ($urandom_range(0, 3) == 0)
            ? bpa_pkg::CountW'($urandom_range(0, cmax))
            : bpa_pkg::CountW'($urandom_range(1, (cmax < 6) ? cmax : 6));
        if (tot > 1000)
            r.start_block = ($urandom_range(0, 1) == 0)
                ? bpa_pkg::IndexW'($urandom_range(0, 255))
                : bpa_pkg::IndexW'($urandom_range(tot - 16, tot - 1));
        else
            r.start_block = bpa_pkg::IndexW'($urandom_range(0, tot + 1));
        return r;
    endfunction

    task automatic random_phase(int unsigned value, int n);
        bpa_pkg::t_req r;
        set_total(value);
        for (int k = 0; k < n; k++) begin
            r = random_word();
            send_word(r, 1'b0, '0);
            if (value == 200 && k == 20) hold_req = 1'b1;
            if (value == 33 && k == 20) drain();
        end
    endtask

    t_row directed [] = '{
        '{bpa_pkg::OP_QUERY,   16'd0,    17'd0,     1'b1,
          '{bpa_pkg::ST_OK,      16'd0, 1'b1, 17'd0}},
        '{bpa_pkg::OP_FIND,    16'd0,    17'd0,     1'b1,
          '{bpa_pkg::ST_OK,      16'd1, 1'b0, 17'd0}},
        '{bpa_pkg::OP_ALLOC,   16'd0,    17'd0,     1'b1,
          '{bpa_pkg::ST_INVALID, 16'd0, 1'b0, 17'd0}},
        '{bpa_pkg::OP_FREE,    16'd0,    17'd1,     1'b1,
          '{bpa_pkg::ST_INVALID, 16'd0, 1'b0, 17'd0}},
        '{3'd5,                16'd7,    17'd3,     1'b1,
          '{bpa_pkg::ST_INVALID, 16'd0, 1'b0, 17'd0}},
        '{3'd6,                16'hFFFF, 17'h1FFFF, 1'b1,
          '{bpa_pkg::ST_INVALID, 16'd0, 1'b0, 17'd0}},
        '{3'd7,                16'd0,    17'd0,     1'b1,
          '{bpa_pkg::ST_INVALID, 16'd0, 1'b0, 17'd0}},
        '{bpa_pkg::OP_ALLOC,   16'd0,    17'd1,     1'b1,
          '{bpa_pkg::ST_OK,      16'd1, 1'b0, 17'd1}},
        '{bpa_pkg::OP_ALLOC,   16'd0,    17'd3,     1'b0, '0},
        '{bpa_pkg::OP_RESERVE, 16'd0,    17'd1,     1'b0, '0},
        '{bpa_pkg::OP_RESERVE, 16'hFFFF, 17'd1,     1'b0, '0},
        '{bpa_pkg::OP_QUERY,   16'hFFFF, 17'd0,     1'b0, '0},
        '{bpa_pkg::OP_FIND,    16'hFFFF, 17'd0,     1'b0, '0},
        '{bpa_pkg::OP_FREE,    16'hFFFF, 17'd1,     1'b0, '0},
        '{bpa_pkg::OP_FIND,    16'hFFFF, 17'd0,     1'b0, '0},
        '{bpa_pkg::OP_FREE,    16'd2,    17'hFFFF,  1'b0, '0},
        '{bpa_pkg::OP_ALLOC,   16'd0,    17'h10000, 1'b0, '0},
        '{bpa_pkg::OP_ALLOC,   16'd0,    17'h1FFFF, 1'b0, '0},
        '{bpa_pkg::OP_RESERVE, 16'd1,    17'h10000, 1'b0, '0},
        '{bpa_pkg::OP_FREE,    16'd1,    17'd2,     1'b0, '0},
        '{bpa_pkg::OP_FREE,    16'd1,    17'd2,     1'b0, '0},
        '{bpa_pkg::OP_QUERY,   16'd1,    17'd0,     1'b0, '0},
        '{bpa_pkg::OP_RESERVE, 16'd3,    17'd4,     1'b0, '0},
        '{bpa_pkg::OP_ALLOC,   16'd0,    17'd2,     1'b0, '0}
    };

    initial begin
        bpa_pkg::t_req r;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed[n]) begin
            r.op          = directed[n].op;
            r.start_block = directed[n].start_block;
            r.count       = directed[n].count;
            send_word(r, directed[n].typed, directed[n].rsp);
        end
        random_phase(64, 60);
        random_phase(1, 15);
        random_phase(0, 10);
        random_phase(200, 60);
        random_phase(33, 40);
        random_phase(131071, 25);
        quiet = 1'b1;
        random_phase(96, 60);
        drain();
        repeat (20) @(negedge i_clk);
        $display("Sent %0d request words and checked %0d response words", words_sent,
                 words_checked);
        $display("Totals covered: reset, 64, 1, 0, 200, 33, 131071 and 96 blocks");
        if (mismatches == 0) begin
            $display("bitmap_page_allocator_tb OK");
        end else begin
            $display("bitmap_page_allocator_tb NOT OK");
        end
        $finish;
    end
endmodule
